FILE: sv/edi_pkg.sv
package edi_pkg;

    // result and radicand widths are fixed by the output field
    localparam int DIST_W = 16;
    localparam int RAD_W  = 2 * DIST_W;
    // partial remainder never exceeds twice the partial root
    localparam int REM_W  = DIST_W + 1;

    typedef logic [DIST_W-1:0] t_dist;
    typedef logic [RAD_W-1:0]  t_rad;

    // data handed from one root cell to the next
    typedef struct packed {
        logic [REM_W-1:0] rem;
        t_dist            root;
        t_rad             rad;
    } t_sqrt_stage;

endpackage

FILE: sv/edi_in_if.sv
interface edi_in_if #(
    parameter int COORD_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] ax;
    logic signed [COORD_BITS-1:0] ay;
    logic signed [COORD_BITS-1:0] bx;
    logic signed [COORD_BITS-1:0] by;

    modport source (output valid, output ax, output ay, output bx, output by, input ready);
    modport sink   (input valid, input ax, input ay, input bx, input by, output ready);
endinterface

FILE: sv/edi_out_if.sv
interface edi_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] distance;

    modport source (output valid, output distance, input ready);
    modport sink   (input valid, input distance, output ready);
endinterface

FILE: sv/edi_front.sv
module edi_front import edi_pkg::*; #(
    parameter int COORD_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic signed [COORD_BITS-1:0] i_ax,
    input  logic signed [COORD_BITS-1:0] i_ay,
    input  logic signed [COORD_BITS-1:0] i_bx,
    input  logic signed [COORD_BITS-1:0] i_by,
    output logic                         o_valid,
    output t_rad                         o_rad
);

    localparam int SQ_W  = 2 * COORD_BITS;
    localparam int SUM_W = SQ_W + 1;

    logic [COORD_BITS-1:0] w_uax, w_uay, w_ubx, w_uby;
    logic [COORD_BITS-1:0] n_dx, n_dy;
    logic [COORD_BITS-1:0] r_dx, r_dy;
    logic [SQ_W-1:0]       r_sqx, r_sqy;
    logic [SUM_W-1:0]      w_sum;
    t_rad                  n_rad;
    t_rad                  r_rad;
    logic                  r_v1, r_v2, r_v3;

    // flipping the sign bit gives offset binary, which orders like the signed value
    assign w_uax = {~i_ax[COORD_BITS-1], i_ax[COORD_BITS-2:0]};
    assign w_uay = {~i_ay[COORD_BITS-1], i_ay[COORD_BITS-2:0]};
    assign w_ubx = {~i_bx[COORD_BITS-1], i_bx[COORD_BITS-2:0]};
    assign w_uby = {~i_by[COORD_BITS-1], i_by[COORD_BITS-2:0]};

    assign n_dx = (w_uax >= w_ubx) ? (w_uax - w_ubx) : (w_ubx - w_uax);
    assign n_dy = (w_uay >= w_uby) ? (w_uay - w_uby) : (w_uby - w_uay);

    assign w_sum = SUM_W'(r_sqx) + SUM_W'(r_sqy);

    generate
        if (SUM_W > RAD_W) begin : g_sat
            assign n_rad = (|w_sum[SUM_W-1:RAD_W]) ? '1 : w_sum[RAD_W-1:0];
        end else begin : g_nosat
            assign n_rad = RAD_W'(w_sum);
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dx  <= n_dx;
            r_dy  <= n_dy;
            r_sqx <= SQ_W'(r_dx) * SQ_W'(r_dx);
            r_sqy <= SQ_W'(r_dy) * SQ_W'(r_dy);
            r_rad <= n_rad;
        end
    end

    assign o_valid = r_v3;
    assign o_rad   = r_rad;

endmodule

FILE: sv/edi_cell.sv
module edi_cell import edi_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  t_sqrt_stage i_prev,
    output logic        o_valid,
    output t_sqrt_stage o_next
);

    localparam int CAND_W = REM_W + 2;

    logic [CAND_W-1:0] w_cand;
    logic [CAND_W-1:0] w_trial;
    logic              w_take;
    t_sqrt_stage       n_stage;
    t_sqrt_stage       r_stage;
    logic              r_valid;

    // bring down the next two radicand bits and try a one in the next root bit
    assign w_cand  = {i_prev.rem, i_prev.rad[RAD_W-1 -: 2]};
    assign w_trial = {1'b0, i_prev.root, 2'b01};
    assign w_take  = (w_cand >= w_trial);

    always_comb begin
        n_stage.rem  = w_take ? REM_W'(w_cand - w_trial) : REM_W'(w_cand);
        n_stage.root = {i_prev.root[DIST_W-2:0], w_take};
        n_stage.rad  = {i_prev.rad[RAD_W-3:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_next  = r_stage;

endmodule

FILE: sv/euclidean_distance_isqrt.sv
// Integer Euclidean distance: for points (ax, ay) and (bx, by) the block returns
// floor(sqrt(dx*dx + dy*dy)), with the sum of squares saturated to 0xFFFFFFFF, so a
// saturated sum gives 65535. Three front stages form the differences, the squares
// and the saturated sum; a row of sixteen root cells then settles one result bit
// each. Data passes the front stages, then the cells; the row is a stalled
// pipeline, so a new point pair is taken every cycle that the output is free or
// being taken. The whole pipeline holds while a result waits at the output.
module euclidean_distance_isqrt import edi_pkg::*; #(
    parameter int COORD_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    edi_in_if.sink    i_pt,
    edi_out_if.source o_dist
);

    logic        w_en;
    logic        w_front_valid;
    t_rad        w_front_rad;
    logic        w_valid [DIST_W+1];
    t_sqrt_stage w_stage [DIST_W+1];

    // advance whenever the output register is empty or its result transfers
    assign w_en       = !w_valid[DIST_W] || o_dist.ready;
    assign i_pt.ready = w_en;

    edi_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_pt.valid),
        .i_ax    (i_pt.ax),
        .i_ay    (i_pt.ay),
        .i_bx    (i_pt.bx),
        .i_by    (i_pt.by),
        .o_valid (w_front_valid),
        .o_rad   (w_front_rad)
    );

    assign w_valid[0]      = w_front_valid;
    assign w_stage[0].rem  = '0;
    assign w_stage[0].root = '0;
    assign w_stage[0].rad  = w_front_rad;

    generate
        for (genvar g = 0; g < DIST_W; g++) begin : g_cell
            edi_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (w_en),
                .i_valid (w_valid[g]),
                .i_prev  (w_stage[g]),
                .o_valid (w_valid[g+1]),
                .o_next  (w_stage[g+1])
            );
        end
    endgenerate

    assign o_dist.valid    = w_valid[DIST_W];
    assign o_dist.distance = w_stage[DIST_W].root;

endmodule
